// ===== hdl/kps_pkg.sv =====
// package for the keyframe parallax selector
// types and codes shared by the selector modules; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package kps_pkg;
    typedef enum logic [1:0] {
        FUNC_TRACK  = 2'd0,
        FUNC_ADD    = 2'd1,
        FUNC_DECIDE = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    localparam logic CFG_THRESHOLD   = 1'b0;
    localparam logic CFG_MIN_TRACKED = 1'b1;

    localparam int THRESHOLD_RESET   = 22795;
    localparam int MIN_TRACKED_RESET = 20;
    localparam logic [8:0] TRACK_SAT = 9'd511;

    // coordinates and the parallax threshold share this fixed-point format
    localparam int COORD_FRAC_BITS = 20;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_SEARCH = 10'b0000000010,
        ST_SWAIT  = 10'b0000000100,
        ST_APPEND = 10'b0000001000,
        ST_SCAN   = 10'b0000010000,
        ST_SWAIT2 = 10'b0000100000,
        ST_PREAD  = 10'b0001000000,
        ST_DIFF   = 10'b0010000000,
        ST_SQRT   = 10'b0100000000,
        ST_RESULT = 10'b1000000000
    } t_state;
endpackage
`default_nettype wire

// ===== hdl/keyframe_parallax_selector_top.sv =====
// keyframe parallax selector top level: feature table, history memory and decide engine
// depends on kps_pkg
// Items are handled one at a time. A track or add item searches the identifier memory
// through its single read port, one entry at a time: each entry read is issued in ST_SWAIT
// and compared in ST_SEARCH, and the search ends at a hit or after the last entry in use.
// A decide item with frame index below 2 or too few tracked features, and an unused
// selector, load their result from their first state after acceptance once the output
// register is free. Any other decide scans every entry in use; an entry that spans frames
// k-2 and k-1 also takes two history reads, a difference, the squaring of both differences
// and 32 square root steps, and the verdict is loaded once the last entry is done and the
// output register is free. Results sit in an output register; the next item may be taken
// while one waits, but its own result holds until the waiting one is delivered. Register
// writes are taken only when the block is idle with no result waiting, and have priority
// over an item offered in the same cycle. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_parallax_selector_top
    import kps_pkg::*;
#(
    parameter int MAX_FEATURES    = 256,
    parameter int WINDOW_FRAMES   = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [3:0]  i_frame_index,
    input  wire logic [30:0] i_feature_id,
    input  wire logic [31:0] i_point_x,
    input  wire logic [31:0] i_point_y,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_is_keyframe,
    output logic             o_id_found,
    output logic             o_dropped,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [30:0] i_cfg_data
);
    localparam int AW  = $clog2(MAX_FEATURES);
    localparam int HW  = $clog2(WINDOW_FRAMES);
    localparam int CW  = AW + 1;
    localparam int LW  = HW + 1;
    localparam int PW  = AW + HW;
    localparam int FW  = ((LW > 4) ? LW : 4) + 1;
    localparam int SW  = 32 + CW;

    // memories
    logic [30:0] m_ids   [MAX_FEATURES];
    logic [3:0]  m_first [MAX_FEATURES];
    logic [LW-1:0] m_len [MAX_FEATURES];
    logic [63:0] m_hist  [MAX_FEATURES*WINDOW_FRAMES];

    t_state r_state, n_state;
    logic [30:0] r_thr;
    logic [8:0]  r_min;
    logic [CW-1:0] r_count;
    logic [8:0]  r_tracked;
    logic [1:0]  r_func;
    logic [3:0]  r_frame;
    logic [30:0] r_id;
    logic [63:0] r_pt;
    logic [CW-1:0] r_idx;
    logic [AW-1:0] r_ent;
    logic r_found;
    logic r_kf, r_fnd, r_drp, r_ovalid;

    // memory read ports, registered
    logic [AW-1:0] w_raddr;
    logic [30:0] r_rid;
    logic [3:0]  r_rfirst;
    logic [LW-1:0] r_rlen;
    logic [PW-1:0] w_haddr;
    logic [PW-1:0] r_haddr;
    logic [63:0] r_rhist;
    logic [63:0] r_pa;

    // memory write controls
    logic w_we_ent, w_we_len, w_we_hist;
    logic [AW-1:0] w_waddr;
    logic [LW-1:0] w_wlen;
    logic [PW-1:0] w_whaddr;

    // decide datapath
    logic [SW-1:0] r_sum;
    logic [CW-1:0] r_num;
    logic [63:0] r_sq;
    logic [31:0] r_root;
    logic [5:0]  r_bit;
    logic [31:0] r_dx, r_dy;
    logic        r_sq_ph;

    // result hand-off
    logic w_out_free, w_force, w_scan_done, w_emit;

    assign o_ready     = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE) && !r_ovalid;
    assign o_valid       = r_ovalid;
    assign o_is_keyframe = r_kf;
    assign o_id_found    = r_fnd;
    assign o_dropped     = r_drp;

    assign w_raddr = r_idx[AW-1:0];
    assign w_haddr = r_haddr;

    // read and write of the table memories
    always_ff @(posedge i_clk) begin
        r_rid    <= m_ids[w_raddr];
        r_rfirst <= m_first[w_raddr];
        r_rlen   <= m_len[w_raddr];
        r_rhist  <= m_hist[w_haddr];
        if (w_we_ent) begin
            m_ids[w_waddr]   <= r_id;
            m_first[w_waddr] <= r_frame;
        end
        if (w_we_len) begin
            m_len[w_waddr] <= w_wlen;
        end
        if (w_we_hist) begin
            m_hist[w_whaddr] <= r_pt;
        end
    end

    // result loads when the output register is free or being emptied
    always_comb begin
        w_out_free  = !r_ovalid || i_ready;
        w_force     = (r_frame < 4'd2) || (r_tracked < r_min);
        w_scan_done = w_force || (r_idx >= r_count);
        case (r_state)
            ST_APPEND, ST_RESULT: w_emit = w_out_free;
            ST_SWAIT2:            w_emit = w_out_free && w_scan_done;
            default:              w_emit = 1'b0;
        endcase
    end

    // span test for the entry read last cycle
    logic [4:0] w_k2;
    logic [FW-1:0] w_fl;
    logic w_span;
    logic [HW-1:0] w_off_a;
    always_comb begin
        w_k2    = {1'b0, r_frame} - 5'd2;
        w_fl    = FW'(r_rfirst) + FW'(r_rlen);
        w_span  = ({1'b0, r_rfirst} <= w_k2) && (w_fl >= FW'(r_frame));
        w_off_a = HW'(w_k2 - {1'b0, r_rfirst});
    end

    // append target and history address
    logic [AW-1:0] w_app_ent;
    logic [LW-1:0] w_app_len;
    always_comb begin
        w_app_ent = r_found ? r_ent : r_count[AW-1:0];
        w_app_len = r_found ? r_rlen : '0;
    end

    // absolute differences of signed values, with saturation
    function automatic logic [31:0] abs_sat(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] d;
        logic [32:0] m;
        d = $signed({a[31], a}) - $signed({b[31], b});
        m = d[32] ? 33'(-d) : 33'(d);
        return (m > 33'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
    endfunction

    logic [63:0] w_cand_sq;
    logic [63:0] w_dx_sq;
    logic [31:0] w_cand;
    logic [SW-1:0] w_thr_n;
    always_comb begin
        w_cand    = r_root | (32'd1 << r_bit[4:0]);
        w_cand_sq = w_cand * w_cand;
        w_dx_sq   = r_dx * r_dx;
        w_thr_n   = SW'(r_thr) * SW'(r_num);
    end

    always_comb begin
        n_state   = r_state;
        w_we_ent  = 1'b0;
        w_we_len  = 1'b0;
        w_we_hist = 1'b0;
        w_waddr   = w_app_ent;
        w_wlen    = w_app_len + LW'(1);
        w_whaddr  = {w_app_ent, w_app_len[HW-1:0]};
        case (r_state)
            ST_APPEND: begin
                if (w_out_free && (!r_found || w_app_len < LW'(WINDOW_FRAMES))) begin
                    if (r_found || r_count < CW'(MAX_FEATURES)) begin
                        w_we_ent  = !r_found;
                        w_we_len  = 1'b1;
                        w_we_hist = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_thr     <= 31'(THRESHOLD_RESET);
            r_min     <= 9'(MIN_TRACKED_RESET);
            r_count   <= '0;
            r_tracked <= '0;
            r_ovalid  <= 1'b0;
            r_idx     <= '0;
        end else begin
            // output register: loaded by a result, emptied on delivery
            r_ovalid <= w_emit || (r_ovalid && !i_ready);
            case (r_state)
                ST_IDLE: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        if (i_cfg_index == CFG_THRESHOLD) r_thr <= i_cfg_data;
                        else r_min <= i_cfg_data[8:0];
                    end
                    if (i_valid && o_ready) begin
                        r_func  <= i_func;
                        r_frame <= i_frame_index;
                        r_id    <= i_feature_id;
                        r_pt    <= {i_point_x, i_point_y};
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_sum   <= '0;
                        r_num   <= '0;
                        if (i_func == FUNC_DECIDE) begin
                            r_state <= ST_SWAIT2;
                        end else if (i_func == FUNC_NONE) begin
                            r_state <= ST_RESULT;
                        end else begin
                            r_state <= ST_SWAIT;
                        end
                    end
                end
                // lookup: address r_idx issued, data valid next cycle
                ST_SWAIT: begin
                    if (r_idx >= r_count) begin
                        r_state <= (t_func'(r_func) == FUNC_ADD) ? ST_APPEND : ST_RESULT;
                    end else begin
                        r_state <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if (r_rid == r_id) begin
                        r_found <= 1'b1;
                        r_ent   <= r_idx[AW-1:0];
                        r_state <= (t_func'(r_func) == FUNC_ADD) ? ST_APPEND : ST_RESULT;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= ST_SWAIT;
                    end
                end
                ST_APPEND: begin
                    // r_rlen still holds the found entry's length
                    if (w_emit) begin
                        r_fnd <= r_found;
                        r_kf  <= 1'b0;
                        if (!r_found && r_count >= CW'(MAX_FEATURES)) begin
                            r_drp <= 1'b1;
                        end else if (r_found && r_rlen >= LW'(WINDOW_FRAMES)) begin
                            r_drp <= 1'b1;
                        end else begin
                            r_drp <= 1'b0;
                            if (!r_found) r_count <= r_count + CW'(1);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                ST_RESULT: begin
                    if (w_emit) begin
                        r_kf <= 1'b0; r_fnd <= r_found; r_drp <= 1'b0;
                        if (r_found && r_tracked < TRACK_SAT) r_tracked <= r_tracked + 9'd1;
                        r_state <= ST_IDLE;
                    end
                end
                // decide scan: entry read issued at r_idx
                ST_SWAIT2: begin
                    if (w_scan_done) begin
                        if (w_emit) begin
                            r_kf  <= w_force || (r_num == '0) || (r_sum >= w_thr_n);
                            r_fnd <= 1'b0; r_drp <= 1'b0;
                            r_tracked <= '0;
                            r_state   <= ST_IDLE;
                        end
                    end else begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_span) begin
                        r_haddr <= {r_idx[AW-1:0], w_off_a};
                        r_state <= ST_PREAD;
                        r_sq_ph <= 1'b0;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= ST_SWAIT2;
                    end
                end
                // two history reads: point a then point b
                ST_PREAD: begin
                    r_sq_ph <= !r_sq_ph;
                    if (!r_sq_ph) begin
                        r_haddr <= r_haddr + PW'(1);
                    end else begin
                        r_state <= ST_DIFF;
                    end
                    if (r_sq_ph) r_pa <= r_rhist;
                end
                ST_DIFF: begin
                    r_dx <= abs_sat(r_pa[63:32], r_rhist[63:32]);
                    r_dy <= abs_sat(r_pa[31:0], r_rhist[31:0]);
                    r_sq_ph <= 1'b0;
                    r_state <= ST_SQRT;
                    r_root  <= '0;
                    r_bit   <= 6'd31;
                end
                ST_SQRT: begin
                    if (!r_sq_ph) begin
                        // square the two differences in turn, dx first and then dy
                        r_sq    <= w_dx_sq;
                        r_dx    <= r_dy;
                        r_sq_ph <= 1'b1;
                        r_bit   <= 6'd32;
                    end else if (r_bit == 6'd32) begin
                        r_sq  <= r_sq + w_dx_sq;
                        r_bit <= 6'd31;
                    end else begin
                        if (w_cand_sq <= r_sq) r_root <= w_cand;
                        if (r_bit == 6'd0) begin
                            // last root bit settles here, accumulate and move on
                            r_sum   <= r_sum + SW'((w_cand_sq <= r_sq) ? w_cand : r_root);
                            r_num   <= r_num + CW'(1);
                            r_idx   <= r_idx + CW'(1);
                            r_state <= ST_SWAIT2;
                        end
                        r_bit <= r_bit - 6'd1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// testbench for the keyframe parallax selector top level
// depends on kps_pkg and keyframe_parallax_selector_top; self-checking with a scoreboard class
`timescale 1ns / 1ps
`default_nettype none
module tb
    import kps_pkg::*;
();

    localparam int NUM_FEAT  = 256;
    localparam int NUM_FRAME = 16;
    localparam int WDOG_MAX  = 200000;

    typedef struct packed {
        logic kf;
        logic found;
        logic drop;
    } t_verdict;

    // selector model plus queue of expected verdicts
    class selector_scoreboard;
        logic [30:0] ids [NUM_FEAT];
        logic [3:0]  firsts [NUM_FEAT];
        int          lens [NUM_FEAT];
        logic [63:0] hist [NUM_FEAT*NUM_FRAME];
        int          n_entries;
        int          n_tracked;
        logic [30:0] thresh;
        logic [8:0]  min_trk;
        t_verdict    pending [$];

        function new();
            n_entries = 0;
            n_tracked = 0;
            thresh    = 31'(THRESHOLD_RESET);
            min_trk   = 9'(MIN_TRACKED_RESET);
        endfunction

        function void set_reg(logic idx, logic [30:0] d);
            if (idx == CFG_THRESHOLD) thresh = d;
            else min_trk = d[8:0];
        endfunction

        function int lookup(logic [30:0] id);
            for (int i = 0; i < n_entries; i++)
                if (ids[i] == id) return i;
            return -1;
        endfunction

        function logic [63:0] sat_abs(logic [31:0] a, logic [31:0] b);
            longint d;
            d = longint'($signed(a)) - longint'($signed(b));
            if (d < 0) d = -d;
            return (d > 64'h7fffffff) ? 64'h7fffffff : 64'(d);
        endfunction

        function logic [63:0] root(logic [63:0] s);
            logic [63:0] r, c;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if (c * c <= s) r = c;
            end
            return r;
        endfunction

        function logic parallax_keyframe(int k);
            logic [63:0] sum, cnt, pa, pb, dx, dy;
            int f;
            sum = 0;
            cnt = 0;
            if (k < 2 || n_tracked < int'(min_trk)) return 1'b1;
            for (int i = 0; i < n_entries; i++) begin
                f = firsts[i];
                if (f <= k - 2 && f + lens[i] >= k) begin
                    pa = hist[i*NUM_FRAME + k - 2 - f];
                    pb = hist[i*NUM_FRAME + k - 1 - f];
                    dx = sat_abs(pa[63:32], pb[63:32]);
                    dy = sat_abs(pa[31:0], pb[31:0]);
                    sum += root(dx * dx + dy * dy);
                    cnt++;
                end
            end
            if (cnt == 0) return 1'b1;
            return sum >= 64'(thresh) * cnt;
        endfunction

        // apply one accepted input item
        function void note_item(t_func fn, logic [3:0] fr, logic [30:0] id,
                                logic [31:0] x, logic [31:0] y);
            t_verdict v;
            int e;
            v = '0;
            case (fn)
                FUNC_TRACK: begin
                    if (lookup(id) >= 0) begin
                        v.found = 1;
                        if (n_tracked < int'(TRACK_SAT)) n_tracked++;
                    end
                end
                FUNC_ADD: begin
                    e = lookup(id);
                    if (e >= 0) v.found = 1;
                    else if (n_entries < NUM_FEAT) begin
                        e = n_entries++;
                        ids[e] = id;
                        firsts[e] = fr;
                        lens[e] = 0;
                    end else v.drop = 1;
                    if (!v.drop) begin
                        if (lens[e] < NUM_FRAME) begin
                            hist[e*NUM_FRAME + lens[e]] = {x, y};
                            lens[e]++;
                        end else v.drop = 1;
                    end
                end
                FUNC_DECIDE: begin
                    v.kf = parallax_keyframe(int'(fr));
                    n_tracked = 0;
                end
                default: ;
            endcase
            pending = {pending, v};
        endfunction

        // compare one delivered result; returns 1 on any mismatch, else 0
        function int check_result(t_verdict got, output string msg);
            t_verdict w;
            msg = "";
            if (pending.size() == 0) begin
                msg = "result with nothing expected";
                return 1;
            end
            w = pending.pop_front();
            if (got.kf !== w.kf) msg = {msg, $sformatf(" is_keyframe %b/%b", got.kf, w.kf)};
            if (got.found !== w.found)
                msg = {msg, $sformatf(" id_found %b/%b", got.found, w.found)};
            if (got.drop !== w.drop) msg = {msg, $sformatf(" dropped %b/%b", got.drop, w.drop)};
            return (msg != "") ? 1 : 0;
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [1:0]  i_func = '0;
    logic [3:0]  i_frame_index = '0;
    logic [30:0] i_feature_id = '0;
    logic [31:0] i_point_x = '0;
    logic [31:0] i_point_y = '0;
    logic        o_valid;
    logic        i_ready = 0;
    logic        o_is_keyframe, o_id_found, o_dropped;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 0;
    logic [30:0] i_cfg_data = '0;

    selector_scoreboard sb;
    int  errors = 0;
    int  idle_cycles = 0;
    int  n_sent = 0;
    logic [30:0] id_pool [32];

    keyframe_parallax_selector_top u_top (.*);

    always #6 i_clk = ~i_clk;

    task automatic report(string s);
        $display("mismatch at %0t:%s", $realtime, s);
        errors++;
    endtask

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    // watchdog on cycles without any handshake on the item, result or register port
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stalls, check on accept
    initial begin : sink
        string m;
        int g;
        t_verdict got;
        wait (i_rst_n);
        forever begin
            g = pick_gap();
            if (g != 0) begin
                i_ready <= 0;
                repeat (g) @(posedge i_clk);
            end
            i_ready <= 1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            got = '{o_is_keyframe, o_id_found, o_dropped};
            if (sb.check_result(got, m) != 0) report(m);
        end
    end

    // valid stays high into the next item when no gap follows
    task automatic send_item(t_func fn, logic [3:0] fr, logic [30:0] id,
                             logic [31:0] x, logic [31:0] y);
        int g;
        i_valid       <= 1;
        i_func        <= fn;
        i_frame_index <= fr;
        i_feature_id  <= id;
        i_point_x     <= x;
        i_point_y     <= y;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_item(fn, fr, id, x, y);
        n_sent++;
        g = pick_gap();
        if (g != 0) begin
            i_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [30:0] d);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, d);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 80000)) - 40000);
        endcase
    endfunction

    // one window: adds over frames mixed with stray random items, tracks, then a decide
    task automatic run_window(int nfeat);
        int last;
        last = $urandom_range(2, 15);
        for (int f = 0; f <= last; f++) begin
            for (int i = 0; i < nfeat; i++)
                if ($urandom_range(0, 5) != 0)
                    send_item(FUNC_ADD, 4'(f), id_pool[i], rand_coord(), rand_coord());
            if ($urandom_range(0, 3) == 0)
                send_item(t_func'($urandom_range(0, 3)), 4'($urandom), 31'($urandom),
                          $urandom, $urandom);
        end
        for (int i = 0; i < nfeat + 2; i++)
            send_item(FUNC_TRACK, 4'($urandom), ($urandom_range(0, 4) == 0) ?
                      31'($urandom) : id_pool[$urandom_range(0, nfeat - 1)], $urandom, $urandom);
        send_item(FUNC_DECIDE, ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'(last),
                  31'($urandom), $urandom, $urandom);
    endtask

    // stimulus
    initial begin : source
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, every selector, full history, small k
        send_item(FUNC_DECIDE, 4'd0, '0, '0, '0);
        send_item(FUNC_DECIDE, 4'd1, '0, '0, '0);
        send_item(FUNC_TRACK, 4'd0, 31'h7fffffff, '0, '0);
        send_item(FUNC_ADD, 4'd0, 31'h7fffffff, 32'h7fffffff, 32'h80000000);
        send_item(FUNC_ADD, 4'd0, 31'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_item(FUNC_ADD, 4'd0, 31'd0, '0, '0);
        send_item(FUNC_ADD, 4'd0, 31'd0, 32'd1048576, 32'hfff00000);
        send_item(FUNC_TRACK, 4'hf, 31'h7fffffff, '1, '1);
        send_item(FUNC_TRACK, 4'hf, 31'd0, '1, '1);
        send_item(FUNC_NONE, 4'hf, 31'h7fffffff, '1, '1);
        send_item(FUNC_DECIDE, 4'd2, '0, '0, '0);
        drain();
        write_reg(CFG_MIN_TRACKED, 31'd0);
        write_reg(CFG_THRESHOLD, 31'd0);
        send_item(FUNC_DECIDE, 4'd2, '0, '0, '0);
        send_item(FUNC_DECIDE, 4'd5, '0, '0, '0);
        drain();
        write_reg(CFG_THRESHOLD, 31'h7fffffff);
        send_item(FUNC_DECIDE, 4'd2, '0, '0, '0);
        for (int i = 0; i < 16; i++)
            send_item(FUNC_ADD, 4'd3, 31'd0, $urandom, $urandom);

        // random windows with register changes between them
        for (int i = 0; i < 32; i++) id_pool[i] = 31'($urandom);
        while (n_sent < 1000) begin
            drain();
            case ($urandom_range(0, 3))
                0: write_reg(CFG_THRESHOLD, 31'($urandom_range(0, 60000)));
                1: write_reg(CFG_THRESHOLD, ($urandom_range(0, 1)) ? 31'h7fffffff : 31'd0);
                2: write_reg(CFG_MIN_TRACKED, 31'($urandom_range(0, 8)));
                default: write_reg(CFG_MIN_TRACKED, ($urandom_range(0, 1)) ? 31'd256 : 31'd0);
            endcase
            run_window($urandom_range(1, 8));
            for (int i = 0; i < 32; i++) id_pool[i] = 31'($urandom);
        end

        // table fill to force full-table drops
        drain();
        for (int i = 0; i < NUM_FEAT + 4; i++)
            send_item(FUNC_ADD, 4'($urandom), 31'(i * 7 + 3), $urandom, $urandom);
        send_item(FUNC_TRACK, '0, 31'd3, '0, '0);
        send_item(FUNC_DECIDE, 4'd9, '0, '0, '0);

        drain();
        repeat (1000) @(posedge i_clk);
        if (errors == 0 && sb.pending.size() == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
hdl/kps_pkg.sv
hdl/keyframe_parallax_selector_top.sv
dv/tb.sv
